FILE: hw/rtl/sblc_pkg.sv
package sblc_pkg;

   // Operation codes of an input item
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Rating write targets
   localparam logic GROUP_UP   = 1'b0;
   localparam logic GROUP_DOWN = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_SENSOR_COUNT = 2'd0;
   localparam logic [1:0] CSR_UP_COUNT     = 2'd1;
   localparam logic [1:0] CSR_DOWN_COUNT   = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   // Level codes
   localparam logic [2:0] LEVEL_HOLD      = 3'd0;
   localparam logic [2:0] LEVEL_RAISE_MIN = 3'd1;
   localparam logic [2:0] LEVEL_RAISE_MID = 3'd2;
   localparam logic [2:0] LEVEL_RAISE_MAX = 3'd3;
   localparam logic [2:0] LEVEL_LOWER_MIN = 3'd4;
   localparam logic [2:0] LEVEL_LOWER_MID = 3'd5;
   localparam logic [2:0] LEVEL_LOWER_MAX = 3'd6;

   // Power requests in watts
   localparam logic [15:0] REQ_NONE = 16'd0;
   localparam logic [15:0] REQ_MIN  = 16'd1000;
   localparam logic [15:0] REQ_MID  = 16'd2000;
   localparam logic [15:0] REQ_MAX  = 16'hffff;

   // ceil(2^17 / 3): (x * DIV3_RECIP) >> 17 is exact x / 3 for 16-bit x
   localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
   localparam int          DIV3_SHIFT = 17;

   localparam int RATING_W = 16;

   typedef struct packed {
      logic        op;
      logic        active;
      logic [15:0] low_aim;
      logic [15:0] high_aim;
      logic [15:0] sensor_a;
      logic [15:0] sensor_b;
      logic [15:0] sensor_c;
      logic [15:0] sensor_d;
      logic        rating_group;
      logic [2:0]  rating_index;
      logic [15:0] rating_watts;
   } req_type;

   typedef struct packed {
      logic [7:0]  up_mask;
      logic [7:0]  down_mask;
      logic [2:0]  level_code;
      logic [15:0] measured;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic step;
   } pick_ctl_type;

endpackage

FILE: hw/rtl/sblc_req_if.sv
interface sblc_req_if import sblc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sblc_rsp_if.sv
interface sblc_rsp_if import sblc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sblc_ram.sv
module sblc_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sblc_pick.sv
module sblc_pick import sblc_pkg::*; #(
   parameter int MAX_OUTLETS = 8,
   parameter int ADDR_W      = (MAX_OUTLETS > 1) ? $clog2(MAX_OUTLETS) : 1
) (
   input  logic                   clock,
   input  pick_ctl_type           ctl,
   input  logic [ADDR_W-1:0]      position,
   input  logic [RATING_W-1:0]    rating,
   input  logic [RATING_W-1:0]    request,
   output logic [MAX_OUTLETS-1:0] mask
);

   logic                   found_ff, found_in;
   logic [ADDR_W-1:0]      match_ff, match_in;
   logic [RATING_W-1:0]    sum_ff, sum_in;
   logic [MAX_OUTLETS-1:0] below_ff, below_in;
   logic [RATING_W:0]      sum_wide;
   logic [RATING_W-1:0]    sum_sat;

   // saturating running total of the ratings seen so far
   assign sum_wide = {1'b0, sum_ff} + {1'b0, rating};
   assign sum_sat  = sum_wide[RATING_W] ? {RATING_W{1'b1}} : sum_wide[RATING_W-1:0];

   always_comb begin
      found_in = found_ff;
      match_in = match_ff;
      sum_in   = sum_ff;
      below_in = below_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
         match_in = '0;
         sum_in   = '0;
         below_in = '0;
      end else if (ctl.step) begin
         // later exact matches override earlier ones
         if (rating == request) begin
            found_in = 1'b1;
            match_in = position;
         end
         sum_in = sum_sat;
         if (sum_sat < request) begin
            below_in = below_ff | (MAX_OUTLETS'(1) << position);
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      match_ff <= match_in;
      sum_ff   <= sum_in;
      below_ff <= below_in;
   end

   always_comb begin
      priority if (request == REQ_NONE) begin
         mask = '0;
      end else if (found_ff) begin
         mask = MAX_OUTLETS'(1) << match_ff;
      end else if (below_ff == '0) begin
         mask = MAX_OUTLETS'(1);
      end else begin
         mask = below_ff;
      end
   end

endmodule

FILE: hw/rtl/staged_band_load_controller.sv
// Staged band load controller.
// Items arrive on req_chan (valid/ready); every accepted item yields exactly
// one result transfer on rsp_chan. A write item (op = write) stores one outlet
// rating and reports the current state; a tick averages the enabled sensors,
// compares the average with the band [low_aim, high_aim] and switches outlets
// of the raising or lowering group according to their ratings.
// The ratings live in two small synchronous RAMs, one per group, walked in
// parallel one entry per cycle by two selection units.
// A write goes from the transfer straight to ST_FINISH; a tick passes through
// ST_DIV, ST_DECIDE, ST_WALK (L entries, none if L is 0) and ST_FINISH,
// where L = max(up_outlet_count, down_outlet_count) clamped to MAX_OUTLETS.
// One item is processed at a time; req_chan.ready is high while idle.
// The result sits in an output register, so a new item is taken while the
// previous result waits; a stalled receiver only holds the next result back.
// Reset (synchronous, active high) clears the on-masks, level, average and
// registers (sensor_count 1, outlet counts 0). Ratings are undefined until
// written. The csr_ port writes a register at any edge with csr_we high.
module staged_band_load_controller import sblc_pkg::*; #(
   parameter int MAX_OUTLETS = 8,
   parameter int MAX_SENSORS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   sblc_req_if.sink               req_chan,
   sblc_rsp_if.source             rsp_chan
);

   localparam int AW = (MAX_OUTLETS > 1) ? $clog2(MAX_OUTLETS) : 1;
   localparam int CW = $clog2(MAX_OUTLETS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DECIDE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [2:0] sensor_count_ff;
   logic [3:0] up_count_ff;
   logic [3:0] down_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_count_ff <= 3'd1;
         up_count_ff     <= '0;
         down_count_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR_COUNT: sensor_count_ff <= csr_wdata[2:0];
            CSR_UP_COUNT:     up_count_ff     <= csr_wdata;
            CSR_DOWN_COUNT:   down_count_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp counts to what the hardware holds
   logic [2:0]    sensors_used;
   logic [CW-1:0] n_up, n_down, walk_len;

   always_comb begin
      if (sensor_count_ff == 3'd0) begin
         sensors_used = 3'd1;
      end else if (32'(sensor_count_ff) > MAX_SENSORS) begin
         sensors_used = 3'(MAX_SENSORS);
      end else begin
         sensors_used = sensor_count_ff;
      end
      n_up     = (32'(up_count_ff) > MAX_OUTLETS) ? CW'(MAX_OUTLETS) : CW'(up_count_ff);
      n_down   = (32'(down_count_ff) > MAX_OUTLETS) ? CW'(MAX_OUTLETS) : CW'(down_count_ff);
      walk_len = (n_up > n_down) ? n_up : n_down;
   end

   // ---------------------------------------------------------------------
   // Control and datapath registers
   // ---------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic                   is_tick_ff, is_tick_in;
   logic                   active_ff, active_in;
   logic [15:0]            low_ff, low_in;
   logic [15:0]            high_ff, high_in;
   logic [15:0]            sum_ff, sum_in;
   logic [2:0]             div_ff, div_in;
   logic [15:0]            avg_ff, avg_in;
   logic [15:0]            up_req_ff, up_req_in;
   logic [15:0]            down_req_ff, down_req_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [MAX_OUTLETS-1:0] up_on_ff, up_on_in;
   logic [MAX_OUTLETS-1:0] down_on_ff, down_on_in;
   logic [2:0]             level_ff, level_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   rsp_free;
   logic [15:0]            sensor_sum;
   logic [31:0]            div3_prod;
   logic [16:0]            avg_x, high_x, low_x;
   logic                   wr_up, wr_down, wr_in_range;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [RATING_W-1:0]    up_rating, down_rating;
   logic [MAX_OUTLETS-1:0] up_pick, down_pick;
   pick_ctl_type           up_ctl, down_ctl;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // wrapping sum of the enabled sensors, taken straight off the request
   always_comb begin
      sensor_sum = req_chan.data.sensor_a;
      if (sensors_used >= 3'd2) sensor_sum = sensor_sum + req_chan.data.sensor_b;
      if (sensors_used >= 3'd3) sensor_sum = sensor_sum + req_chan.data.sensor_c;
      if (sensors_used >= 3'd4) sensor_sum = sensor_sum + req_chan.data.sensor_d;
   end

   assign div3_prod = 32'(sum_ff) * 32'(DIV3_RECIP);

   assign avg_x  = {1'b0, avg_ff};
   assign high_x = {1'b0, high_ff};
   assign low_x  = {1'b0, low_ff};

   // rating writes go to the RAM in the transfer cycle itself
   assign wr_in_range = (32'(req_chan.data.rating_index) < MAX_OUTLETS);
   assign wr_up   = req_fire && (req_chan.data.op == OP_WRITE) && wr_in_range
                    && (req_chan.data.rating_group == GROUP_UP);
   assign wr_down = req_fire && (req_chan.data.op == OP_WRITE) && wr_in_range
                    && (req_chan.data.rating_group == GROUP_DOWN);
   assign wr_addr = AW'(req_chan.data.rating_index);

   // read one entry ahead: data of entry idx_ff arrives while in ST_WALK
   assign rd_addr = idx_in[AW-1:0];

   always_comb begin
      up_ctl.clear   = (state_ff == ST_DECIDE);
      down_ctl.clear = (state_ff == ST_DECIDE);
      up_ctl.step    = (state_ff == ST_WALK) && (idx_ff < n_up);
      down_ctl.step  = (state_ff == ST_WALK) && (idx_ff < n_down);
   end

   always_comb begin
      state_in     = state_ff;
      is_tick_in   = is_tick_ff;
      active_in    = active_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      sum_in       = sum_ff;
      div_in       = div_ff;
      avg_in       = avg_ff;
      up_req_in    = up_req_ff;
      down_req_in  = down_req_ff;
      idx_in       = idx_ff;
      up_on_in     = up_on_ff;
      down_on_in   = down_on_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the held result once it is taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_tick_in = (req_chan.data.op == OP_TICK);
               active_in  = req_chan.data.active;
               low_in     = req_chan.data.low_aim;
               high_in    = req_chan.data.high_aim;
               sum_in     = sensor_sum;
               div_in     = sensors_used;
               // a write leaves masks, level and average unchanged: report right away
               state_in   = (req_chan.data.op == OP_TICK) ? ST_DIV : ST_FINISH;
            end
         end

         ST_DIV: begin
            unique case (div_ff)
               3'd2:    avg_in = sum_ff >> 1;
               3'd3:    avg_in = 16'(div3_prod >> DIV3_SHIFT);
               3'd4:    avg_in = sum_ff >> 2;
               default: avg_in = sum_ff;
            endcase
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            up_req_in   = REQ_NONE;
            down_req_in = REQ_NONE;
            if (active_ff) begin
               if (avg_x > high_x) begin
                  if (n_down != '0) begin
                     if (avg_x > high_x + 17'd2) begin
                        down_req_in = REQ_MAX;
                        level_in    = LEVEL_LOWER_MAX;
                     end else if (avg_x > high_x + 17'd1) begin
                        down_req_in = REQ_MID;
                        level_in    = LEVEL_LOWER_MID;
                     end else begin
                        down_req_in = REQ_MIN;
                        level_in    = LEVEL_LOWER_MIN;
                     end
                  end else begin
                     level_in = LEVEL_HOLD;
                  end
               end else if (n_up != '0) begin
                  if (avg_x + 17'd2 < low_x) begin
                     up_req_in = REQ_MAX;
                     level_in  = LEVEL_RAISE_MAX;
                  end else if (avg_x + 17'd1 < low_x) begin
                     up_req_in = REQ_MID;
                     level_in  = LEVEL_RAISE_MID;
                  end else if (avg_x < low_x) begin
                     up_req_in = REQ_MIN;
                     level_in  = LEVEL_RAISE_MIN;
                  end else begin
                     level_in = LEVEL_HOLD;
                  end
               end
            end
            idx_in   = '0;
            state_in = (walk_len == '0) ? ST_FINISH : ST_WALK;
         end

         ST_WALK: begin
            // advance through both groups in lockstep
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) == walk_len) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hold until the output register is free
            if (rsp_free) begin
               if (is_tick_ff) begin
                  if (n_up != '0) up_on_in = up_pick;
                  if (n_down != '0) down_on_in = down_pick;
               end
               rsp_valid_in           = 1'b1;
               rsp_data_in.up_mask    = 8'((is_tick_ff && n_up != '0) ? up_pick : up_on_ff);
               rsp_data_in.down_mask  =
                  8'((is_tick_ff && n_down != '0) ? down_pick : down_on_ff);
               rsp_data_in.level_code = level_ff;
               // avg_ff only changes on a tick, so it is the last measure
               rsp_data_in.measured   = avg_ff;
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= '0;
         up_on_ff     <= '0;
         down_on_ff   <= '0;
         level_ff     <= LEVEL_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         up_on_ff     <= up_on_in;
         down_on_ff   <= down_on_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_tick_ff  <= is_tick_in;
      active_ff   <= active_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      sum_ff      <= sum_in;
      div_ff      <= div_in;
      up_req_ff   <= up_req_in;
      down_req_ff <= down_req_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Rating stores and selection units
   // ---------------------------------------------------------------------
   sblc_ram #(
      .WIDTH  (RATING_W),
      .DEPTH  (MAX_OUTLETS),
      .ADDR_W (AW)
   ) u_up_ram (
      .clock   (clock),
      .wr_en   (wr_up),
      .wr_addr (wr_addr),
      .wr_data (req_chan.data.rating_watts),
      .rd_addr (rd_addr),
      .rd_data (up_rating)
   );

   sblc_ram #(
      .WIDTH  (RATING_W),
      .DEPTH  (MAX_OUTLETS),
      .ADDR_W (AW)
   ) u_down_ram (
      .clock   (clock),
      .wr_en   (wr_down),
      .wr_addr (wr_addr),
      .wr_data (req_chan.data.rating_watts),
      .rd_addr (rd_addr),
      .rd_data (down_rating)
   );

   sblc_pick #(
      .MAX_OUTLETS (MAX_OUTLETS),
      .ADDR_W      (AW)
   ) u_up_pick (
      .clock    (clock),
      .ctl      (up_ctl),
      .position (idx_ff[AW-1:0]),
      .rating   (up_rating),
      .request  (up_req_ff),
      .mask     (up_pick)
   );

   sblc_pick #(
      .MAX_OUTLETS (MAX_OUTLETS),
      .ADDR_W      (AW)
   ) u_down_pick (
      .clock    (clock),
      .ctl      (down_ctl),
      .position (idx_ff[AW-1:0]),
      .rating   (down_rating),
      .request  (down_req_ff),
      .mask     (down_pick)
   );

endmodule
